### hw/rtl/lpsd_pkg.sv
`timescale 1ns / 1ps

package lpsd_pkg;

    // Panel geometry and timing.
    localparam int COLUMNS      = 64;
    localparam int ROWS         = 32;
    localparam int TICKS_PER_US = 50;

    localparam int HALF_ROWS  = ROWS / 2;
    localparam int HALF_DEPTH = HALF_ROWS * COLUMNS;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
    localparam int ADDR_W     = $clog2(HALF_DEPTH);
    localparam int LIT_W      = 16;
    localparam int ROW_SEL_W  = 4;
    localparam int RGB_W      = 3;
    localparam int ON_TIME_W  = 7;

    localparam logic [ON_TIME_W-1:0] ON_TIME_MAX   = 7'd100;
    localparam logic [ON_TIME_W-1:0] ON_TIME_RESET = 7'd20;

    // Item kinds; the fourth code is ignored.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // RGB565 channel masks.
    localparam logic [15:0] MASK_RED   = 16'hF800;
    localparam logic [15:0] MASK_GREEN = 16'h07E0;
    localparam logic [15:0] MASK_BLUE  = 16'h001F;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  pixel_x;
        logic [4:0]  pixel_y;
        logic [15:0] pixel_color;
    } lpsd_req_t;

    typedef struct packed {
        logic [RGB_W-1:0]     upper_rgb;
        logic [RGB_W-1:0]     lower_rgb;
        logic [ROW_SEL_W-1:0] row_select;
        logic                 shift_clock;
        logic                 latch_strobe;
        logic                 blank_n;
    } lpsd_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tick;
        logic fetch_cap;
        logic pix_wr;
        logic clr_step;
    } lpsd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_fetch;
        logic clr_last;
    } lpsd_sts_t;

    // Each color bit is set when any bit of its RGB565 channel is set.
    function automatic logic [RGB_W-1:0] rgb565_bits(input logic [15:0] color);
        return {|(color & MASK_RED), |(color & MASK_GREEN), |(color & MASK_BLUE)};
    endfunction

endpackage

### hw/rtl/lpsd_ram.sv
`timescale 1ns / 1ps

module lpsd_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

### hw/rtl/lpsd_ctrl.sv
`timescale 1ns / 1ps

module lpsd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic [1:0]         req_kind,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  lpsd_pkg::lpsd_sts_t sts,
    output lpsd_pkg::lpsd_cmd_t cmd
);

    import lpsd_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   accept;

    // An item is taken only when the result slot is free or drains this cycle.
    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd.tick      = accept && (req_kind == KIND_TICK);
        cmd.pix_wr    = accept && (req_kind == KIND_PIXEL);
        cmd.fetch_cap = (state_reg == ST_FETCH);
        cmd.clr_step  = (state_reg == ST_CLEAR);
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (req_kind == KIND_CLEAR))
                begin
                    state_next = ST_CLEAR;
                end
                else if (cmd.tick)
                begin
                    if (sts.need_fetch)
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        rsp_valid_next = 1'b1;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next     = ST_IDLE;
                rsp_valid_next = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_fetch_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FETCH |=> state_reg == ST_IDLE)
        else $error("fetch state lasted more than one cycle");

    a_fetch_gives_item: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FETCH |=> rsp_valid_reg)
        else $error("fetch did not produce a result item");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !req_ready)
        else $error("item accepted during clearing pass");

    a_clear_item_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req_kind == KIND_CLEAR) |=> state_reg == ST_CLEAR)
        else $error("clear item did not start clearing pass");

endmodule

### hw/rtl/lpsd_dpath.sv
`timescale 1ns / 1ps

module lpsd_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  lpsd_pkg::lpsd_req_t  req,
    input  lpsd_pkg::lpsd_cmd_t  cmd,
    output lpsd_pkg::lpsd_sts_t  sts,
    input  logic                cfg_valid,
    input  logic [6:0]          cfg_data,
    output lpsd_pkg::lpsd_rsp_t  rsp
);

    import lpsd_pkg::*;

    typedef enum logic [1:0] {
        PH_SHIFT,
        PH_LATCH,
        PH_LIT,
        PH_BLANK
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [ROW_W-1:0]       scan_row_reg, scan_row_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic                   half_reg, half_next;
    logic [LIT_W-1:0]       lit_reg, lit_next;
    logic [ROW_SEL_W-1:0]   row_sel_reg, row_sel_next;
    logic [2*RGB_W-1:0]     held_reg, held_next;
    logic [ON_TIME_W-1:0]   on_time_reg, on_time_next;
    logic [ADDR_W-1:0]      clr_cnt_reg, clr_cnt_next;
    lpsd_rsp_t              rsp_reg, rsp_next;
    logic                   rsp_load;

    logic                   pin_clk, pin_lat, pin_blank_n;
    logic [LIT_W-1:0]       lit_load;

    logic                   pix_ok, pix_lower;
    logic [ROW_W-1:0]       pix_row;
    logic [ADDR_W-1:0]      pix_addr, rd_addr, wr_addr;
    logic [RGB_W-1:0]       wr_data, rd_upper, rd_lower;
    logic                   we_upper, we_lower;

    // Pixel write decode.
    assign pix_ok    = (int'(req.pixel_x) < COLUMNS) && (int'(req.pixel_y) < ROWS);
    assign pix_lower = (int'(req.pixel_y) >= HALF_ROWS);
    assign pix_row   = pix_lower ? ROW_W'(int'(req.pixel_y) - HALF_ROWS) : ROW_W'(req.pixel_y);
    assign pix_addr  = ADDR_W'(int'(pix_row) * COLUMNS + int'(req.pixel_x));

    assign wr_addr  = cmd.clr_step ? clr_cnt_reg : pix_addr;
    assign wr_data  = cmd.clr_step ? '0 : rgb565_bits(req.pixel_color);
    assign we_upper = cmd.clr_step || (cmd.pix_wr && pix_ok && !pix_lower);
    assign we_lower = cmd.clr_step || (cmd.pix_wr && pix_ok && pix_lower);
    assign rd_addr  = ADDR_W'(int'(scan_row_reg) * COLUMNS + int'(col_reg));

    lpsd_ram #(
        .WIDTH (RGB_W),
        .DEPTH (HALF_DEPTH)
    ) u_ram_upper (
        .clk   (clk),
        .we    (we_upper),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_upper)
    );

    lpsd_ram #(
        .WIDTH (RGB_W),
        .DEPTH (HALF_DEPTH)
    ) u_ram_lower (
        .clk   (clk),
        .we    (we_lower),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_lower)
    );

    assign sts.need_fetch = (phase_reg == PH_SHIFT) && !half_reg;
    assign sts.clr_last   = (clr_cnt_reg == ADDR_W'(HALF_DEPTH - 1));

    assign lit_load = LIT_W'(LIT_W'(on_time_reg) * LIT_W'(TICKS_PER_US));

    always_comb
    begin
        phase_next    = phase_reg;
        scan_row_next = scan_row_reg;
        col_next      = col_reg;
        half_next     = half_reg;
        lit_next      = lit_reg;
        row_sel_next  = row_sel_reg;
        held_next     = held_reg;
        pin_clk       = 1'b0;
        pin_lat       = 1'b0;
        pin_blank_n   = 1'b1;
        if (cmd.tick)
        begin
            unique case (phase_reg)
                PH_SHIFT:
                begin
                    if (!half_reg)
                    begin
                        // Data for this column arrives from memory next cycle.
                        half_next = 1'b1;
                    end
                    else
                    begin
                        pin_clk   = 1'b1;
                        half_next = 1'b0;
                        if (col_reg == COL_W'(COLUMNS - 1))
                        begin
                            col_next   = '0;
                            phase_next = PH_LATCH;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                end
                PH_LATCH:
                begin
                    row_sel_next = ROW_SEL_W'(scan_row_reg);
                    pin_lat      = 1'b1;
                    lit_next     = lit_load;
                    phase_next   = (lit_load != '0) ? PH_LIT : PH_BLANK;
                end
                PH_LIT:
                begin
                    pin_blank_n = 1'b0;
                    if (lit_reg != '0)
                    begin
                        lit_next = lit_reg - 1'b1;
                    end
                    if (lit_reg <= LIT_W'(1))
                    begin
                        phase_next = PH_BLANK;
                    end
                end
                PH_BLANK:
                begin
                    if (scan_row_reg == ROW_W'(HALF_ROWS - 1))
                    begin
                        scan_row_next = '0;
                    end
                    else
                    begin
                        scan_row_next = scan_row_reg + 1'b1;
                    end
                    col_next   = '0;
                    half_next  = 1'b0;
                    phase_next = PH_SHIFT;
                end
                default:
                begin
                    phase_next = PH_SHIFT;
                end
            endcase
        end
        if (cmd.fetch_cap)
        begin
            held_next = {rd_upper, rd_lower};
        end
    end

    always_comb
    begin
        rsp_load              = (cmd.tick && !sts.need_fetch) || cmd.fetch_cap;
        rsp_next.upper_rgb    = held_next[2*RGB_W-1:RGB_W];
        rsp_next.lower_rgb    = held_next[RGB_W-1:0];
        rsp_next.row_select   = row_sel_next;
        rsp_next.shift_clock  = pin_clk;
        rsp_next.latch_strobe = pin_lat;
        rsp_next.blank_n      = pin_blank_n;
    end

    always_comb
    begin
        on_time_next = on_time_reg;
        if (cfg_valid)
        begin
            on_time_next = (cfg_data > ON_TIME_MAX) ? ON_TIME_MAX : cfg_data;
        end
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clr_step)
        begin
            clr_cnt_next = sts.clr_last ? '0 : clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SHIFT;
            scan_row_reg <= '0;
            col_reg      <= '0;
            half_reg     <= 1'b0;
            lit_reg      <= '0;
            row_sel_reg  <= '0;
            held_reg     <= '0;
            on_time_reg  <= ON_TIME_RESET;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            scan_row_reg <= scan_row_next;
            col_reg      <= col_next;
            half_reg     <= half_next;
            lit_reg      <= lit_next;
            row_sel_reg  <= row_sel_next;
            held_reg     <= held_next;
            on_time_reg  <= on_time_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

### hw/rtl/led_panel_scan_driver_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  lpsd_req_t: kind, pixel_x, pixel_y, pixel_color
// rsp       out        rsp_valid / rsp_ready  lpsd_rsp_t: pin levels for one tick
// cfg       in         cfg_valid / cfg_ready  cfg_data: on_time_us, clamped to 100
//
// A tick on the low half of a column also passes through the fetch state, since both frame
// store halves are read through their registered read port.
// A clear item blocks the req channel for one pass over the HALF_DEPTH (1024) store addresses.
// After reset the same clearing pass runs before the first item is taken.
// The result register holds one item; req_ready drops while it is full and not being taken.
// The cfg channel is always ready, also during a clearing pass.

module led_panel_scan_driver_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  lpsd_pkg::lpsd_req_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output lpsd_pkg::lpsd_rsp_t  rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [6:0]          cfg_data
);

    import lpsd_pkg::*;

    lpsd_cmd_t cmd;
    lpsd_sts_t sts;

    // The on-time register can be written at any time the cfg channel offers an item.
    assign cfg_ready = 1'b1;

    // The controller sequences item acceptance, the memory fetch and the clearing pass.
    lpsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_kind  (req.kind),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the frame store, the scan counters and the result register.
    lpsd_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .rsp       (rsp)
    );

endmodule

### dv/lpsd_scan_checker.sv
`timescale 1ns / 1ps

module lpsd_scan_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  lpsd_pkg::lpsd_req_t req,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  lpsd_pkg::lpsd_rsp_t rsp,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [6:0]         cfg_data,
    output int                 fail_count,
    output int                 pending
);

    import lpsd_pkg::*;

    typedef enum logic [1:0] {
        SCAN_SHIFT,
        SCAN_LATCH,
        SCAN_LIT,
        SCAN_BLANK
    } scan_step_t;

    // Local copy of the panel state.
    logic [RGB_W-1:0] frame_bits [0:ROWS*COLUMNS-1];
    logic [6:0]       lit_us;
    scan_step_t       step;
    int               scan_row;
    int               column;
    logic             clock_high;
    int               lit_left;
    logic [3:0]       shown_row;
    logic [5:0]       shown_data;

    lpsd_rsp_t        pins_due[$];
    int               mismatches;

    task automatic clear_frame();
        for (int i = 0; i < ROWS * COLUMNS; i++)
        begin
            frame_bits[i] = '0;
        end
    endtask

    // One tick of the scan sequence: advance the state and return the pin levels.
    task automatic scan_tick(output lpsd_rsp_t pins);
        pins         = '0;
        pins.blank_n = 1'b1;
        case (step)
            SCAN_SHIFT:
            begin
                if (!clock_high)
                begin
                    shown_data = {frame_bits[scan_row * COLUMNS + column],
                                  frame_bits[(scan_row + HALF_ROWS) * COLUMNS + column]};
                    clock_high = 1'b1;
                end
                else
                begin
                    pins.shift_clock = 1'b1;
                    clock_high       = 1'b0;
                    if (column == COLUMNS - 1)
                    begin
                        column = 0;
                        step   = SCAN_LATCH;
                    end
                    else
                    begin
                        column++;
                    end
                end
            end
            SCAN_LATCH:
            begin
                shown_row         = scan_row[3:0];
                pins.latch_strobe = 1'b1;
                lit_left          = int'(lit_us) * TICKS_PER_US;
                step              = (lit_left != 0) ? SCAN_LIT : SCAN_BLANK;
            end
            SCAN_LIT:
            begin
                pins.blank_n = 1'b0;
                if (lit_left > 0)
                begin
                    lit_left--;
                end
                if (lit_left == 0)
                begin
                    step = SCAN_BLANK;
                end
            end
            default:
            begin
                scan_row   = (scan_row == HALF_ROWS - 1) ? 0 : scan_row + 1;
                column     = 0;
                clock_high = 1'b0;
                step       = SCAN_SHIFT;
            end
        endcase
        pins.upper_rgb  = shown_data[5:3];
        pins.lower_rgb  = shown_data[2:0];
        pins.row_select = shown_row;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lpsd_rsp_t want;
        lpsd_rsp_t pins;
        if (!rst_n)
        begin
            clear_frame();
            lit_us     = ON_TIME_RESET;
            step       = SCAN_SHIFT;
            scan_row   = 0;
            column     = 0;
            clock_high = 1'b0;
            lit_left   = 0;
            shown_row  = '0;
            shown_data = '0;
            mismatches = 0;
            pins_due.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // A result leaves in the cycle after its item at the earliest, so take it before this edge's item.
            if (rsp_valid && rsp_ready)
            begin
                if (pins_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no result, got %h", $time, rsp);
                end
                else
                begin
                    want = pins_due.pop_front();
                    check_field("upper_rgb", 8'(want.upper_rgb), 8'(rsp.upper_rgb));
                    check_field("lower_rgb", 8'(want.lower_rgb), 8'(rsp.lower_rgb));
                    check_field("row_select", 8'(want.row_select), 8'(rsp.row_select));
                    check_field("shift_clock", 8'(want.shift_clock), 8'(rsp.shift_clock));
                    check_field("latch_strobe", 8'(want.latch_strobe),
                                8'(rsp.latch_strobe));
                    check_field("blank_n", 8'(want.blank_n), 8'(rsp.blank_n));
                end
            end
            if (req_valid && req_ready)
            begin
                case (req.kind)
                    KIND_TICK:
                    begin
                        scan_tick(pins);
                        pins_due.push_back(pins);
                    end
                    KIND_PIXEL:
                    begin
                        frame_bits[int'(req.pixel_y) * COLUMNS + int'(req.pixel_x)] =
                            {req.pixel_color[15:11] != 0,
                             req.pixel_color[10:5] != 0,
                             req.pixel_color[4:0] != 0};
                    end
                    KIND_CLEAR:
                    begin
                        clear_frame();
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cfg_valid && cfg_ready)
            begin
                lit_us = (cfg_data > ON_TIME_MAX) ? ON_TIME_MAX : cfg_data;
            end
            pending    <= pins_due.size();
            fail_count <= mismatches;
        end
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

// Testbench top. This module only generates stimulus and gives the verdict; all
// prediction and comparison of the pin levels happens in the checker beside the block.
module tb_top;

    import lpsd_pkg::*;

    // The fourth kind code is not in the package; the block must ignore it.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // A clear item can keep the block busy for a whole store pass after the last
    // result has come out, so every quiet period covers that pass with some margin.
    localparam int SETTLE_CYCLES = HALF_DEPTH + 64;
    localparam int LONG_HOLD     = 200;
    localparam int LIMIT_CYCLES  = 600_000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    lpsd_req_t  req       = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    lpsd_rsp_t  rsp;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [6:0] cfg_data  = '0;

    int         fail_count;
    int         pending;

    // Shared control between the stimulus and the result sink: the batch number
    // being run, and a calm flag that switches all idling off near the end.
    int         batch_id  = -1;
    bit         calm      = 1'b0;

    always #2 clk = ~clk;

    led_panel_scan_driver_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lpsd_scan_checker pin_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Result sink. It alternates ready stretches of varying length with short stalls.
    // Once, at the start of the first random batch, it holds off for a long stretch
    // while the sender keeps offering items, so the result register fills and the
    // block has to stall its input.
    initial
    begin
        bit held_once;
        held_once = 1'b0;
        @(posedge clk);
        forever
        begin
            if (!held_once && batch_id == 1)
            begin
                held_once = 1'b1;
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("led_panel_scan_driver_core: mismatch");
        $finish;
    end

    function automatic lpsd_req_t make_item(input logic [1:0] kind, input int x,
                                            input int y, input logic [15:0] color);
        lpsd_req_t item;
        item             = '0;
        item.kind        = kind;
        item.pixel_x     = x[5:0];
        item.pixel_y     = y[4:0];
        item.pixel_color = color;
        return item;
    endfunction

    // Mostly scan ticks so that the sequencer gets through many rows; pixel writes
    // keep changing what is shifted out, and clears and unused kinds are rare.
    function automatic lpsd_req_t random_item();
        lpsd_req_t item;
        int        pick;
        item             = '0;
        item.pixel_x     = 6'($urandom_range(0, COLUMNS - 1));
        item.pixel_y     = 5'($urandom_range(0, ROWS - 1));
        case ($urandom_range(0, 5))
            0:       item.pixel_color = 16'(1 << $urandom_range(0, 15));
            1:       item.pixel_color = 16'h0000;
            2:       item.pixel_color = 16'hFFFF;
            default: item.pixel_color = 16'($urandom);
        endcase
        pick = $urandom_range(0, 999);
        if (pick < 900)
        begin
            item.kind = KIND_TICK;
        end
        else if (pick < 980)
        begin
            item.kind = KIND_PIXEL;
        end
        else if (pick < 995)
        begin
            item.kind = KIND_UNUSED;
        end
        else
        begin
            item.kind = KIND_CLEAR;
        end
        return item;
    endfunction

    // Offer one item, sometimes after a short gap, and return at the edge that takes it.
    // Valid stays high on return so back-to-back items need no extra cycle.
    task automatic send_item(input lpsd_req_t item);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Let every outstanding result drain and any clearing pass finish, then set the
    // on time and run a batch of random items under it.
    task automatic run_batch(input int id, input logic [6:0] on_time, input int count);
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= on_time;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        batch_id = id;
        repeat (count) send_item(random_item());
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, under the reset on time. The block runs its clearing pass
        // first, which simply shows up as a long wait for the first handshake.
        // An unused kind comes first: it must leave no trace.
        send_item(make_item(KIND_UNUSED, COLUMNS - 1, ROWS - 1, 16'hFFFF));
        // Each color channel alone, at full value and at its lowest bit, in the first
        // columns of both halves of scan row 0, so the ticks below shift them out.
        send_item(make_item(KIND_PIXEL, 0, 0, 16'hF800));
        send_item(make_item(KIND_PIXEL, 0, HALF_ROWS, 16'h07E0));
        send_item(make_item(KIND_PIXEL, 1, 0, 16'h001F));
        send_item(make_item(KIND_PIXEL, 1, HALF_ROWS, 16'hFFFF));
        send_item(make_item(KIND_PIXEL, 2, 0, 16'h0800));
        send_item(make_item(KIND_PIXEL, 2, HALF_ROWS, 16'h0020));
        send_item(make_item(KIND_PIXEL, 3, 0, 16'h0001));
        send_item(make_item(KIND_PIXEL, 3, HALF_ROWS, 16'h0000));
        send_item(make_item(KIND_PIXEL, 4, 0, 16'hFFFF));
        // Overwrite of a pixel already set, and the far corners of the panel.
        send_item(make_item(KIND_PIXEL, 0, 0, 16'h07FF));
        send_item(make_item(KIND_PIXEL, COLUMNS - 1, ROWS - 1, 16'hFFFF));
        send_item(make_item(KIND_PIXEL, COLUMNS - 1, HALF_ROWS - 1, 16'hF81F));
        repeat (8) send_item(make_item(KIND_TICK, 0, 0, 16'h0000));
        // A clear in the middle of shifting a row: the columns after it read back dark.
        send_item(make_item(KIND_CLEAR, COLUMNS - 1, ROWS - 1, 16'hFFFF));
        repeat (4) send_item(make_item(KIND_TICK, COLUMNS - 1, ROWS - 1, 16'hFFFF));

        // Random part. Short on times keep rows turning over so the row address keeps changing;
        // zero on time skips the lit phase entirely. The long receiver hold-off happens during
        // the first batch.
        run_batch(1, 7'd0, 1100);
        run_batch(2, 7'd1, 200);
        run_batch(3, 7'($urandom_range(2, 4)), 100);
        run_batch(4, 7'd0, 300);
        // The largest legal value, then a write above it that must saturate. The long
        // lit phase comes last, since it would stall the row sequence for 5000 ticks.
        run_batch(5, ON_TIME_MAX, 0);
        calm = 1'b1;
        run_batch(6, 7'd127, 150);

        // Wait for every expected result, then give the block time to show any extra one.
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("led_panel_scan_driver_core: match");
        end
        else
        begin
            $display("led_panel_scan_driver_core: mismatch");
        end
        $finish;
    end

endmodule
